// ===== rtl/sbe_pkg.sv =====
package sbe_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ModeW = 4;
  localparam int unsigned AddrW = 8;
  localparam int unsigned DepthW = 7;
  localparam int unsigned StatW = 3;

  localparam logic [ModeW-1:0] OpPush  = 4'd0;
  localparam logic [ModeW-1:0] OpPop   = 4'd1;
  localparam logic [ModeW-1:0] OpAdd   = 4'd2;
  localparam logic [ModeW-1:0] OpSub   = 4'd3;
  localparam logic [ModeW-1:0] OpMul   = 4'd4;
  localparam logic [ModeW-1:0] OpDiv   = 4'd5;
  localparam logic [ModeW-1:0] OpLoad  = 4'd6;
  localparam logic [ModeW-1:0] OpStore = 4'd7;
  localparam logic [ModeW-1:0] OpRet   = 4'd8;

  localparam logic [StatW-1:0] StOk      = 3'd0;
  localparam logic [StatW-1:0] StUnder   = 3'd1;
  localparam logic [StatW-1:0] StOver    = 3'd2;
  localparam logic [StatW-1:0] StUnknown = 3'd3;
  localparam logic [StatW-1:0] StDivZero = 3'd4;

  typedef enum logic [2:0] {
    CmdHold = 3'b001,
    CmdPush = 3'b010,
    CmdPop  = 3'b100
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic              wr_top;
    logic [DataW-1:0]  data;
  } cell_ctl_t;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StRead  = 6'b000010,
    StMul   = 6'b000100,
    StDiv   = 6'b001000,
    StApply = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  function automatic logic [DataW-1:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] mx;
    logic signed [65:0] mn;
    begin
      mx = 66'sd2147483647;
      mn = -66'sd2147483648;
      if (v > mx) sat32 = 32'h7fffffff;
      else if (v < mn) sat32 = 32'h80000000;
      else sat32 = v[DataW-1:0];
    end
  endfunction

endpackage

// ===== rtl/sbe_if.sv =====
interface sbe_in_if;
  import sbe_pkg::*;
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [DataW-1:0] value;
  logic [AddrW-1:0] address;
  modport source (output valid, mode, value, address, input ready);
  modport sink (input valid, mode, value, address, output ready);
endinterface

interface sbe_out_if;
  import sbe_pkg::*;
  logic              valid;
  logic              ready;
  logic [DataW-1:0]  top_value;
  logic [DepthW-1:0] depth;
  logic [StatW-1:0]  status;
  modport source (output valid, top_value, depth, status, input ready);
  modport sink (input valid, top_value, depth, status, output ready);
endinterface

// ===== rtl/sbe_cell.sv =====
module sbe_cell
  import sbe_pkg::*;
(
  input  logic             clk_i,
  input  cell_ctl_t        ctl_i,
  input  logic             is_top_i,
  input  logic [DataW-1:0] above_i,
  input  logic [DataW-1:0] below_i,
  output logic [DataW-1:0] val_o
);

  logic [DataW-1:0] val_q;
  logic [DataW-1:0] val_d;

  always_comb begin
    val_d = val_q;
    case (ctl_i.cmd)
      CmdPush: val_d = above_i;
      CmdPop:  val_d = below_i;
      default: val_d = val_q;
    endcase
    if (ctl_i.cmd == CmdPop && ctl_i.wr_top && is_top_i) val_d = ctl_i.data;
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ===== rtl/sbe_divider.sv =====
module sbe_divider
  import sbe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] num_i,
  input  logic [DataW-1:0] den_i,
  output logic             done_o,
  output logic [DataW-1:0] quo_o
);

  localparam int unsigned NumW = 48;

  logic [NumW-1:0]  rem_q, rem_d;
  logic [NumW-1:0]  quo_q, quo_d;
  logic [DataW-1:0] den_q, den_d;
  logic             neg_q, neg_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [NumW:0]    trial;
  logic signed [65:0] sres;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      quo_d  = num_i[DataW-1] ? -{{(NumW-DataW){num_i[DataW-1]}}, num_i} << 16
                              : {{(NumW-DataW){1'b0}}, num_i} << 16;
      den_d  = den_i[DataW-1] ? -den_i : den_i;
      neg_d  = num_i[DataW-1] ^ den_i[DataW-1];
      rem_d  = '0;
      cnt_d  = 6'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[NumW-1]} - {{(NumW+1-DataW){1'b0}}, den_q};
      if (!trial[NumW]) begin
        rem_d = trial[NumW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[NumW-2:0], quo_q[NumW-1]};
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    sres = neg_q ? -$signed({18'd0, quo_q}) : $signed({18'd0, quo_q});
    quo_o = sat32(sres);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;

endmodule

// ===== rtl/stack_bytecode_executor_unit.sv =====
// An accepted request passes through the read, apply and output states; multiply adds
// a state for the product, and divide waits on a 48-step restoring divider.
// One request at a time: the next is taken the cycle after the result leaves,
// so a new request is not taken while one is still in flight.
// The stack is a row of register cells that shift one place on push and pop.
// Reset clears the stack count, the variable valid bits and all control state.
module stack_bytecode_executor_unit
  import sbe_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned VAR_COUNT = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  sbe_in_if.sink    in_i,
  sbe_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VarAW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

  state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ModeW-1:0] mode_q;
  logic [DataW-1:0] value_q;
  logic [AddrW-1:0] addr_q;
  logic [DataW-1:0] res_q, res_d;
  logic [DataW-1:0] var_rd_q;
  logic [VAR_COUNT-1:0] valid_q;
  logic [DataW-1:0] vmem [VAR_COUNT];
  logic signed [63:0] prod_q;
  logic [DataW-1:0] top_q;
  logic [DepthW-1:0] depth_q;
  logic [StatW-1:0] stat_q, stat_d;
  cell_ctl_t        ctl;
  logic [DataW-1:0] vals [STACK_DEPTH];
  logic [DataW-1:0] a, b;
  logic             addr_ok;
  logic [VarAW-1:0] vaddr;
  logic             div_start, div_done;
  logic [DataW-1:0] div_q;
  logic             vwe;
  logic signed [65:0] ext;

  assign a = vals[1];
  assign b = vals[0];
  assign addr_ok = {24'd0, addr_q} < 32'(VAR_COUNT);
  assign vaddr = VarAW'(addr_q);

  genvar g;
  generate
    for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
      logic [DataW-1:0] above, below;
      if (g == 0) begin : g_first
        assign above = ctl.data;
      end else begin : g_mid
        assign above = vals[g-1];
      end
      if (g == STACK_DEPTH - 1) begin : g_last
        assign below = vals[g];
      end else begin : g_inner
        assign below = vals[g+1];
      end
      sbe_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl),
        .is_top_i(g == 0),
        .above_i (above),
        .below_i (below),
        .val_o   (vals[g])
      );
    end
  endgenerate

  sbe_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (a),
    .den_i  (b),
    .done_o (div_done),
    .quo_o  (div_q)
  );

  function automatic logic [DataW-1:0] vals_next_top();
    begin
      case (ctl.cmd)
        CmdPush: vals_next_top = ctl.data;
        CmdPop:  vals_next_top = ctl.wr_top ? ctl.data : vals[1];
        default: vals_next_top = vals[0];
      endcase
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (vwe) vmem[vaddr] <= b;
    var_rd_q <= vmem[vaddr];
    prod_q <= $signed(a) * $signed(b);
    if (in_i.valid && in_i.ready) begin
      mode_q  <= in_i.mode;
      value_q <= in_i.value;
      addr_q  <= in_i.address;
    end
    res_q <= res_d;
    if (state_q == StApply) begin
      top_q   <= (cnt_d != '0) ? vals_next_top() : '0;
      depth_q <= DepthW'(cnt_d);
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    stat_d    = stat_q;
    div_start = 1'b0;
    vwe       = 1'b0;
    ext       = '0;
    ctl.cmd   = CmdHold;
    ctl.wr_top = 1'b0;
    ctl.data  = value_q;
    case (state_q)
      StIdle: begin
        if (in_i.valid) state_d = StRead;
      end
      StRead: begin
        stat_d = StOk;
        state_d = StApply;
        case (mode_q)
          OpPush: if (cnt_q >= CntW'(STACK_DEPTH)) stat_d = StOver;
          OpPop:  if (cnt_q == '0) stat_d = StUnder;
          OpAdd, OpSub, OpMul, OpDiv: begin
            if (cnt_q < CntW'(2)) stat_d = StUnder;
            else if (mode_q == OpAdd) begin
              ext = $signed({{34{a[DataW-1]}}, a}) + $signed({{34{b[DataW-1]}}, b});
              res_d = sat32(ext);
            end else if (mode_q == OpSub) begin
              ext = $signed({{34{a[DataW-1]}}, a}) - $signed({{34{b[DataW-1]}}, b});
              res_d = sat32(ext);
            end else if (mode_q == OpMul) state_d = StMul;
            else if (b == '0) stat_d = StDivZero;
            else begin
              div_start = 1'b1;
              state_d = StDiv;
            end
          end
          OpLoad: begin
            if (!addr_ok || !valid_q[vaddr]) stat_d = StUnknown;
            else if (cnt_q >= CntW'(STACK_DEPTH)) stat_d = StOver;
          end
          OpStore: begin
            if (cnt_q == '0) stat_d = StUnder;
            else if (!addr_ok) stat_d = StUnknown;
          end
          default: stat_d = StOk;
        endcase
      end
      StMul: begin
        ext = $signed({{2{prod_q[63]}}, prod_q}) >>> 16;
        res_d = sat32(ext);
        state_d = StApply;
      end
      StDiv: begin
        if (div_done) begin
          res_d = div_q;
          state_d = StApply;
        end
      end
      StApply: begin
        state_d = StOut;
        if (stat_q == StOk) begin
          case (mode_q)
            OpPush: begin
              ctl.cmd = CmdPush;
              cnt_d = cnt_q + CntW'(1);
            end
            OpLoad: begin
              ctl.cmd = CmdPush;
              ctl.data = var_rd_q;
              cnt_d = cnt_q + CntW'(1);
            end
            OpPop: begin
              ctl.cmd = CmdPop;
              cnt_d = cnt_q - CntW'(1);
            end
            OpStore: begin
              ctl.cmd = CmdPop;
              vwe = 1'b1;
              cnt_d = cnt_q - CntW'(1);
            end
            OpAdd, OpSub, OpMul, OpDiv: begin
              ctl.cmd = CmdPop;
              ctl.wr_top = 1'b1;
              ctl.data = res_q;
              cnt_d = cnt_q - CntW'(1);
            end
            default: ctl.cmd = CmdHold;
          endcase
        end
      end
      StOut: begin
        if (out_o.ready) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      valid_q <= '0;
      stat_q  <= StOk;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      stat_q  <= stat_d;
      if (vwe) valid_q[vaddr] <= 1'b1;
    end
  end

  assign in_i.ready = (state_q == StIdle);
  assign out_o.valid = (state_q == StOut);
  assign out_o.top_value = top_q;
  assign out_o.depth = depth_q;
  assign out_o.status = stat_q;

endmodule

// ===== bench/tb_scoreboard.sv =====
package tb_scoreboard_pkg;
  import sbe_pkg::*;

  typedef struct packed {
    logic [DataW-1:0]  top_value;
    logic [DepthW-1:0] depth;
    logic [StatW-1:0]  status;
  } exec_result_t;

  class executor_scoreboard;
    int unsigned stack_limit;
    logic signed [DataW-1:0] operands[$];
    logic signed [DataW-1:0] globals[256];
    bit globals_valid[256];
    exec_result_t pending_results[$];
    int unsigned error_count;

    function new(int unsigned depth_limit);
      stack_limit = depth_limit;
      error_count = 0;
      foreach (globals_valid[i]) globals_valid[i] = 1'b0;
    endfunction

    function logic signed [DataW-1:0] saturate(logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[DataW-1:0];
    endfunction

    function void note_request(logic [ModeW-1:0] mode, logic signed [DataW-1:0] value,
                               logic [AddrW-1:0] address);
      logic [StatW-1:0] status;
      logic signed [DataW-1:0] a;
      logic signed [DataW-1:0] b;
      logic signed [DataW-1:0] r;
      logic signed [65:0] wide;
      logic signed [65:0] quot;
      exec_result_t res;
      int unsigned n;
      status = StOk;
      n = operands.size();
      case (mode)
        OpPush: begin
          if (n >= stack_limit) status = StOver;
          else operands = {operands, value};
        end
        OpPop: begin
          if (n == 0) status = StUnder;
          else operands.delete(n-1);
        end
        OpAdd, OpSub, OpMul, OpDiv: begin
          if (n < 2) begin
            status = StUnder;
          end else begin
            a = operands[n-2];
            b = operands[n-1];
            if (mode == OpAdd) begin
              r = saturate(66'(a) + 66'(b));
            end else if (mode == OpSub) begin
              r = saturate(66'(a) - 66'(b));
            end else if (mode == OpMul) begin
              wide = 66'(a) * 66'(b);
              r = saturate(wide >>> 16);
            end else if (b == 0) begin
              status = StDivZero;
            end else begin
              wide = 66'(a) * 66'sd65536;
              quot = wide / 66'(b);
              r = saturate(quot);
            end
            if (status == StOk) begin
              operands.delete(n-1);
              operands[n-2] = r;
            end
          end
        end
        OpLoad: begin
          if (!globals_valid[address]) status = StUnknown;
          else if (n >= stack_limit) status = StOver;
          else operands = {operands, globals[address]};
        end
        OpStore: begin
          if (n == 0) begin
            status = StUnder;
          end else begin
            globals[address] = operands[n-1];
            globals_valid[address] = 1'b1;
            operands.delete(n-1);
          end
        end
        default: ;
      endcase
      res.top_value = (operands.size() > 0) ? operands[operands.size()-1] : '0;
      res.depth = DepthW'(operands.size());
      res.status = status;
      pending_results = {pending_results, res};
    endfunction

    function void check_result(exec_result_t got);
      exec_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      if (got.top_value !== want.top_value) begin
        $error("top_value expected %h actual %h", want.top_value, got.top_value);
        error_count++;
      end
      if (got.depth !== want.depth) begin
        $error("depth expected %0d actual %0d", want.depth, got.depth);
        error_count++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        error_count++;
      end
    endfunction
  endclass
endpackage

// ===== bench/tb_top.sv =====
module tb_top;
  import sbe_pkg::*;
  import tb_scoreboard_pkg::*;

  localparam int unsigned Depth = 64;

  logic clk_i;
  logic rst_ni;
  sbe_in_if in_ch();
  sbe_out_if out_ch();
  executor_scoreboard board;
  bit stimulus_done;

  stack_bytecode_executor_unit #(.STACK_DEPTH(Depth), .VAR_COUNT(256)) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_ch.sink),
    .out_o(out_ch.source)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic int unsigned gap_length();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(20, 4);
    return $urandom_range(80, 21);
  endfunction

  function automatic logic [DataW-1:0] random_value();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(8) << 16;
      3: return 32'($signed($urandom_range(65535) - 32768));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(logic [ModeW-1:0] mode, logic [DataW-1:0] value,
                              logic [AddrW-1:0] address, bit idle_ok);
    int unsigned gap;
    gap = idle_ok ? gap_length() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.value <= value;
    in_ch.address <= address;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_request(mode, value, address);
  endtask

  task automatic random_request();
    logic [ModeW-1:0] mode;
    int unsigned p;
    int unsigned n;
    n = board.operands.size();
    p = $urandom_range(99);
    if (p < 3) mode = ModeW'($urandom_range(15, 8));
    else if (n < 2 && p < 50) mode = OpPush;
    else if (n > Depth - 4 && p < 50) mode = OpPop;
    else if (p < 25) mode = OpPush;
    else if (p < 35) mode = OpLoad;
    else mode = ModeW'($urandom_range(7, 1));
    send_request(mode, random_value(), AddrW'($urandom_range(15)) | (p[0] ? AddrW'($urandom) : '0),
                 ($urandom_range(9) != 0));
  endtask

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.value = '0;
    in_ch.address = '0;
    out_ch.ready = 1'b0;
    stimulus_done = 1'b0;
    board = new(Depth);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_request(OpPop, '0, '0, 1'b0);
    send_request(OpAdd, '0, '0, 1'b0);
    send_request(OpStore, '0, 8'd1, 1'b0);
    send_request(OpLoad, '0, 8'd255, 1'b0);
    send_request(OpPush, 32'h7fffffff, '0, 1'b0);
    send_request(OpPush, 32'h7fffffff, '0, 1'b0);
    send_request(OpAdd, '0, '0, 1'b0);
    send_request(OpPush, 32'h80000000, '0, 1'b0);
    send_request(OpSub, '0, '0, 1'b0);
    send_request(OpPush, 32'hffff8000, '0, 1'b0);
    send_request(OpMul, '0, '0, 1'b0);
    send_request(OpPush, '0, '0, 1'b0);
    send_request(OpDiv, '0, '0, 1'b0);
    send_request(OpPush, 32'h00000001, '0, 1'b0);
    send_request(OpDiv, '0, '0, 1'b0);
    send_request(OpStore, '0, 8'd255, 1'b0);
    send_request(OpLoad, '0, 8'd255, 1'b0);
    send_request(OpRet, '0, '0, 1'b0);
    send_request(4'd15, '0, '0, 1'b0);
    for (int i = 0; i < Depth + 1; i++) send_request(OpLoad, '0, 8'd255, 1'b0);
    for (int i = 0; i < Depth; i++) send_request(OpPop, '0, '0, 1'b0);
    for (int i = 0; i < 2000; i++) random_request();
    in_ch.valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        board.check_result({out_ch.top_value, out_ch.depth, out_ch.status});
      end
      if ($urandom_range(3) == 0) out_ch.ready <= 1'b0;
      else if ($urandom_range(30) == 0) out_ch.ready <= 1'b0;
      else out_ch.ready <= (gap_length() == 0) || $urandom_range(1);
    end
  end

  initial begin
    wait (stimulus_done);
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("FAILURE");
    $finish;
  end
endmodule
